// ----- sv/phgb_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, beat layouts and the arctangent table for the polar height grid.
// No dependencies; every other file of the block imports this package.
package phgb_pkg;

	localparam int MAX_RINGS_DEF   = 32;
	localparam int MAX_SECTORS_DEF = 64;
	localparam int ANGLE_BITS_DEF  = 16;
	localparam int CORDIC_STEPS    = 28;

	localparam int OP_W   = 2;
	localparam int IN_W   = 72;
	localparam int OUT_W  = 40;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 20;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_BIN   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	localparam logic [CFG_AW-1:0] CFG_RING_COUNT   = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_SECTOR_COUNT = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_MIN_RANGE    = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_MAX_RANGE    = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_HEIGHT_LOW   = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_HEIGHT_HIGH  = 3'd5;

	localparam logic [5:0]         RING_COUNT_RST   = 6'd20;
	localparam logic [6:0]         SECTOR_COUNT_RST = 7'd60;
	localparam logic [19:0]        MIN_RANGE_RST    = 20'd0;
	localparam logic [19:0]        MAX_RANGE_RST    = 20'd80000;
	localparam logic signed [19:0] HEIGHT_LOW_RST   = -20'sd5000;
	localparam logic signed [19:0] HEIGHT_HIGH_RST  = 20'sd5000;

	typedef struct packed {
		logic              pad;
		logic [5:0]        read_sector;
		logic [4:0]        read_ring;
		logic signed [19:0] point_z;
		logic signed [19:0] point_y;
		logic signed [19:0] point_x;
	} in_t;

	typedef struct packed {
		logic [6:0]         ring_occupied;
		logic signed [19:0] cell_height;
		logic               cell_valid;
		logic [5:0]         sector_index;
		logic [4:0]         ring_index;
		logic               accepted;
	} res_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- sv/polar_height_grid_binning_core.sv -----
`timescale 1ns / 1ps
// Polar ring/sector height grid: bins points, keeps per-cell maximum heights and ring counts.
// Depends on phgb_pkg. Cell state lives in one synchronous memory with registered read data.
// The angle of a binned point comes from the 28-step CORDIC angle unit; ring search
// runs beside it as a binary search through states S_TA and S_TB for each ring index bit.
// A cell read runs S_RD, S_UPD, S_FIN; opcode 3 goes to S_FIN; a clear writes every cell first.
// One beat is in flight at a time; the next beat is taken while a result waits at the output.
// After reset a clearing pass over all MAX_RINGS*MAX_SECTORS cells (2048 by default) runs before
// the first beat is accepted; configuration registers return to their reset values at once.
module polar_height_grid_binning_core #(
	parameter int MAX_RINGS   = phgb_pkg::MAX_RINGS_DEF,
	parameter int MAX_SECTORS = phgb_pkg::MAX_SECTORS_DEF,
	parameter int ANGLE_BITS  = phgb_pkg::ANGLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// point_x, point_y, point_z, read_ring, read_sector, one zero pad bit
	input  logic [phgb_pkg::IN_W-1:0]   s_axis_tdata,
	// opcode
	input  logic [phgb_pkg::OP_W-1:0]   s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// accepted, ring_index, sector_index, cell_valid, cell_height, ring_occupied
	output logic [phgb_pkg::OUT_W-1:0]  m_axis_tdata,
	input  logic                        cfg_we,
	input  logic [phgb_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [phgb_pkg::CFG_DW-1:0] cfg_wdata
);
	import phgb_pkg::*;

	localparam int DEPTH = MAX_RINGS * MAX_SECTORS;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int RB    = MAX_RINGS > 1 ? $clog2(MAX_RINGS) : 1;
	localparam int SB    = MAX_SECTORS > 1 ? $clog2(MAX_SECTORS) : 1;
	localparam int BW    = RB > 1 ? $clog2(RB) : 1;
	localparam int RCW   = $clog2(MAX_RINGS + 1);
	localparam int SCW   = $clog2(MAX_SECTORS + 1);
	localparam int OCW   = SCW;
	localparam int LW1   = 40 + RCW;
	localparam int LW    = 40 + 2 * RCW;
	localparam int TW    = 21 + RCW;
	localparam int CW    = 2 * TW;
	localparam int PW    = ANGLE_BITS + SCW;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_CLEAR = 13'b0000000000010,
		S_SQ    = 13'b0000000000100,
		S_R2    = 13'b0000000001000,
		S_WIN   = 13'b0000000010000,
		S_LHS   = 13'b0000000100000,
		S_TA    = 13'b0000001000000,
		S_TB    = 13'b0000010000000,
		S_ANG   = 13'b0000100000000,
		S_SEC   = 13'b0001000000000,
		S_RD    = 13'b0010000000000,
		S_UPD   = 13'b0100000000000,
		S_FIN   = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [5:0]         ring_count_q;
	logic [6:0]         sector_count_q;
	logic [19:0]        min_range_q;
	logic [19:0]        max_range_q;
	logic signed [19:0] height_low_q;
	logic signed [19:0] height_high_q;

	in_t                in_w;
	logic [RCW-1:0]     rc;
	logic [SCW-1:0]     sc;
	logic               cfg_bad;

	logic [OP_W-1:0]    op_q;
	logic signed [19:0] x_q;
	logic signed [19:0] y_q;
	logic signed [19:0] z_q;
	logic [38:0]        xx_q;
	logic [38:0]        yy_q;
	logic [39:0]        minsq_q;
	logic [39:0]        maxsq_q;
	logic [39:0]        r2_q;
	logic [LW1-1:0]     lhs1_q;
	logic [LW-1:0]      lhs_q;
	logic [TW-1:0]      base_q;
	logic [19:0]        span_q;
	logic [TW-1:0]      t_q;
	logic [RB-1:0]      ring_q;
	logic [BW-1:0]      bit_q;
	logic [SB-1:0]      sector_q;
	logic [PW-1:0]      prod_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      clr_ptr_q;
	logic               clr_res_q;
	res_t               res_q;
	res_t               out_q;
	logic               out_valid_q;

	logic signed [33:0] cx_q;
	logic signed [33:0] cy_q;
	logic [31:0]        acc_q;
	logic [4:0]         ci_q;
	logic               cord_run_q;

	logic [OCW-1:0]     ring_occ_q [MAX_RINGS];

	logic [20:0]        cell_mem [DEPTH];
	logic [20:0]        mem_rdata_q;
	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	logic [20:0]        mem_wdata;

	logic signed [39:0] xe;
	logic signed [39:0] ye;
	logic signed [39:0] sq_x;
	logic signed [39:0] sq_y;
	logic [RB-1:0]      cand_w;
	logic               cand_ok;
	logic [CW-1:0]      t2_w;
	logic [SCW-1:0]     sec_raw;
	logic [SCW-1:0]     sec_w;
	logic               occ_w;
	logic signed [19:0] h_w;
	logic [OCW-1:0]     cnt_w;
	logic               raise_w;
	logic signed [33:0] x1_w;
	logic signed [33:0] y1_w;
	logic signed [33:0] xs_w;
	logic signed [33:0] ys_w;

	assign in_w = in_t'(s_axis_tdata);

	always_comb begin
		if (32'(ring_count_q) > MAX_RINGS) begin
			rc = RCW'(MAX_RINGS);
		end else begin
			rc = RCW'(ring_count_q);
		end
		if (32'(sector_count_q) > MAX_SECTORS) begin
			sc = SCW'(MAX_SECTORS);
		end else begin
			sc = SCW'(sector_count_q);
		end
	end

	assign cfg_bad = (rc == '0) || (sc == '0) || (max_range_q <= min_range_q) ||
		(height_high_q <= height_low_q);

	assign xe      = {{20{x_q[19]}}, x_q};
	assign ye      = {{20{y_q[19]}}, y_q};
	assign sq_x    = xe * xe;
	assign sq_y    = ye * ye;
	assign cand_w  = ring_q | (RB'(1) << bit_q);
	assign cand_ok = 32'(cand_w) < 32'(rc);
	assign t2_w    = CW'(t_q) * CW'(t_q);
	assign sec_raw = prod_q[PW-1:ANGLE_BITS];
	assign sec_w   = (sec_raw > sc - SCW'(1)) ? sc - SCW'(1) : sec_raw;
	assign occ_w   = mem_rdata_q[20];
	assign h_w     = mem_rdata_q[19:0];
	assign cnt_w   = ring_occ_q[ring_q];
	assign raise_w = !occ_w || (z_q > h_w);
	assign x1_w    = {{4{x_q[19]}}, x_q, 10'b0};
	assign y1_w    = {{4{y_q[19]}}, y_q, 10'b0};
	assign xs_w    = cx_q >>> ci_q;
	assign ys_w    = cy_q >>> ci_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = idx_q;
		mem_wdata = {1'b1, z_q};
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_addr  = clr_ptr_q;
			mem_wdata = '0;
		end else if (state_q == S_UPD && op_q == OP_BIN && raise_w) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem[mem_addr] <= mem_wdata;
		end
		mem_rdata_q <= cell_mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q   <= RING_COUNT_RST;
			sector_count_q <= SECTOR_COUNT_RST;
			min_range_q    <= MIN_RANGE_RST;
			max_range_q    <= MAX_RANGE_RST;
			height_low_q   <= HEIGHT_LOW_RST;
			height_high_q  <= HEIGHT_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_RING_COUNT:   ring_count_q   <= cfg_wdata[5:0];
				CFG_SECTOR_COUNT: sector_count_q <= cfg_wdata[6:0];
				CFG_MIN_RANGE:    min_range_q    <= cfg_wdata;
				CFG_MAX_RANGE:    max_range_q    <= cfg_wdata;
				CFG_HEIGHT_LOW:   height_low_q   <= cfg_wdata;
				CFG_HEIGHT_HIGH:  height_high_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q       <= '0;
			cy_q       <= '0;
			acc_q      <= '0;
			ci_q       <= '0;
			cord_run_q <= 1'b0;
		end else if (state_q == S_SQ) begin
			ci_q <= '0;
			if (y_q == '0) begin
				acc_q      <= x_q < 0 ? 32'h8000_0000 : 32'h0;
				cord_run_q <= 1'b0;
			end else if (x_q == '0) begin
				acc_q      <= y_q > 0 ? 32'h4000_0000 : 32'hC000_0000;
				cord_run_q <= 1'b0;
			end else begin
				cord_run_q <= 1'b1;
				if (x_q < 0) begin
					cx_q  <= -x1_w;
					cy_q  <= -y1_w;
					acc_q <= 32'h8000_0000;
				end else begin
					cx_q  <= x1_w;
					cy_q  <= y1_w;
					acc_q <= 32'h0;
				end
			end
		end else if (cord_run_q) begin
			if (cy_q > 0) begin
				cx_q  <= cx_q + ys_w;
				cy_q  <= cy_q - xs_w;
				acc_q <= acc_q + atan_turn(ci_q);
			end else begin
				cx_q  <= cx_q - ys_w;
				cy_q  <= cy_q + xs_w;
				acc_q <= acc_q - atan_turn(ci_q);
			end
			ci_q <= ci_q + 5'd1;
			if (ci_q == 5'(CORDIC_STEPS - 1)) begin
				cord_run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_ptr_q   <= '0;
			clr_res_q   <= 1'b0;
			op_q        <= OP_NONE;
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
			xx_q        <= '0;
			yy_q        <= '0;
			minsq_q     <= '0;
			maxsq_q     <= '0;
			r2_q        <= '0;
			lhs1_q      <= '0;
			lhs_q       <= '0;
			base_q      <= '0;
			span_q      <= '0;
			t_q         <= '0;
			ring_q      <= '0;
			bit_q       <= '0;
			sector_q    <= '0;
			prod_q      <= '0;
			idx_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_RINGS; i++) begin
				ring_occ_q[i] <= '0;
			end
		end else begin
			if (state_q == S_FIN && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q  <= s_axis_tuser;
						x_q   <= in_w.point_x;
						y_q   <= in_w.point_y;
						z_q   <= in_w.point_z;
						res_q <= '0;
						case (s_axis_tuser)
							OP_CLEAR: begin
								clr_ptr_q <= '0;
								clr_res_q <= 1'b1;
								for (int i = 0; i < MAX_RINGS; i++) begin
									ring_occ_q[i] <= '0;
								end
								state_q <= S_CLEAR;
							end
							OP_BIN: state_q <= S_SQ;
							OP_READ: begin
								res_q.ring_index   <= in_w.read_ring;
								res_q.sector_index <= in_w.read_sector;
								if (32'(in_w.read_ring) < MAX_RINGS &&
									32'(in_w.read_sector) < MAX_SECTORS) begin
									ring_q  <= RB'(in_w.read_ring);
									idx_q   <= AW'(32'(in_w.read_ring) * MAX_SECTORS +
										32'(in_w.read_sector));
									state_q <= S_RD;
								end else begin
									state_q <= S_FIN;
								end
							end
							OP_NONE: state_q <= S_FIN;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_CLEAR: begin
					clr_ptr_q <= clr_ptr_q + AW'(1);
					if (clr_ptr_q == AW'(DEPTH - 1)) begin
						state_q <= clr_res_q ? S_FIN : S_IDLE;
					end
				end
				S_SQ: begin
					xx_q    <= sq_x[38:0];
					yy_q    <= sq_y[38:0];
					minsq_q <= 40'(min_range_q) * 40'(min_range_q);
					maxsq_q <= 40'(max_range_q) * 40'(max_range_q);
					state_q <= S_R2;
				end
				S_R2: begin
					r2_q    <= 40'(xx_q) + 40'(yy_q);
					span_q  <= max_range_q - min_range_q;
					state_q <= S_WIN;
				end
				S_WIN: begin
					if (cfg_bad || r2_q < minsq_q || r2_q > maxsq_q ||
						z_q < height_low_q || z_q > height_high_q) begin
						state_q <= S_FIN;
					end else begin
						lhs1_q  <= LW1'(r2_q) * LW1'(rc);
						base_q  <= TW'(min_range_q) * TW'(rc);
						state_q <= S_LHS;
					end
				end
				S_LHS: begin
					lhs_q   <= LW'(lhs1_q) * LW'(rc);
					ring_q  <= '0;
					bit_q   <= BW'(RB - 1);
					state_q <= S_TA;
				end
				S_TA: begin
					t_q     <= base_q + TW'(cand_w) * TW'(span_q);
					state_q <= S_TB;
				end
				S_TB: begin
					if (cand_ok && CW'(lhs_q) >= t2_w) begin
						ring_q <= cand_w;
					end
					if (bit_q == '0) begin
						state_q <= S_ANG;
					end else begin
						bit_q   <= bit_q - BW'(1);
						state_q <= S_TA;
					end
				end
				S_ANG: begin
					if (!cord_run_q) begin
						prod_q  <= PW'(acc_q[31 -: ANGLE_BITS]) * PW'(sc);
						state_q <= S_SEC;
					end
				end
				S_SEC: begin
					sector_q <= SB'(sec_w);
					idx_q    <= AW'(32'(ring_q) * MAX_SECTORS + 32'(sec_w));
					state_q  <= S_RD;
				end
				S_RD: state_q <= S_UPD;
				S_UPD: begin
					if (op_q == OP_BIN) begin
						res_q.accepted     <= 1'b1;
						res_q.ring_index   <= 5'(ring_q);
						res_q.sector_index <= 6'(sector_q);
						res_q.cell_valid   <= 1'b1;
						res_q.cell_height  <= raise_w ? z_q : h_w;
						if (!occ_w) begin
							ring_occ_q[ring_q]  <= cnt_w + OCW'(1);
							res_q.ring_occupied <= 7'(cnt_w + OCW'(1));
						end else begin
							res_q.ring_occupied <= 7'(cnt_w);
						end
					end else begin
						res_q.cell_valid    <= occ_w;
						res_q.cell_height   <= occ_w ? h_w : '0;
						res_q.ring_occupied <= 7'(cnt_w);
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || m_axis_tready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	a_upd_write_bin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && mem_we) |-> (op_q == OP_BIN))
		else $error("cell store written by a beat that is not a point");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && !m_axis_tready) |=> (state_q == S_FIN))
		else $error("result staged over an untaken output beat");

	a_ring_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ANG) |-> (32'(ring_q) < 32'(rc)))
		else $error("ring search left the rings in use");

	a_angle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEC) |-> !cord_run_q)
		else $error("sector taken before the angle unit finished");

endmodule
